// ----- hdl/cle_pkg.sv -----
package cle_pkg;

  // request codes
  typedef enum logic [3:0] {
    REQ_INS_AFTER  = 4'd0,
    REQ_INS_BEFORE = 4'd1,
    REQ_GET        = 4'd2,
    REQ_REMOVE     = 4'd3,
    REQ_BEGIN      = 4'd4,
    REQ_END        = 4'd5,
    REQ_NEXT       = 4'd6,
    REQ_PRIOR      = 4'd7,
    REQ_CLEAR      = 4'd8
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GET_W,
    ST_NEXT_W,
    ST_ALLOC_W,
    ST_INS,
    ST_AFT_W,
    ST_AFT_LINK,
    ST_REM_W,
    ST_WALK,
    ST_WALK_W
  } state_t;

  localparam int VAL_W   = 32;
  localparam int REQ_W   = 4;
  localparam int COUNT_W = 5;

endpackage

// ----- hdl/cle_if.sv -----
interface cle_req_if;
  import cle_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] value_in;
  modport source (output valid, req_type, value_in, input ready);
  modport sink   (input valid, req_type, value_in, output ready);
endinterface

interface cle_rsp_if;
  import cle_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic signed [VAL_W-1:0] value_out;
  logic                    is_empty;
  logic                    is_full;
  logic [COUNT_W-1:0]      count;
  modport source (output valid, ok, value_out, is_empty, is_full, count, input ready);
  modport sink   (input valid, ok, value_out, is_empty, is_full, count, output ready);
endinterface

// ----- hdl/cle_ram.sv -----
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read on one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/cursor_list_engine.sv -----
// Channel   Dir  Handshake      Payload
// in_req    in   valid/ready    req_type, value_in
// out_rsp   out  valid/ready    ok, value_out, is_empty, is_full, count
//
// Walks to a predecessor or to the end step one link at a time, alternating ST_WALK
// and ST_WALK_W, through the single link RAM port.
// One request is in flight; a new beat is taken once the result has left.
// Reset (rst_n low, synchronous) empties the list; RAM contents need no clearing.
// A stalled result holds in the output register until out_rsp.ready.
module cursor_list_engine
  import cle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  cle_req_if.sink   in_req,
  cle_rsp_if.source out_rsp
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;

  logic [SW-1:0] head_r, head_nxt, cur_r, cur_nxt, pos_r, pos_nxt;
  logic [SW-1:0] fhead_r, fhead_nxt, new_r, new_nxt, nx_r, nx_nxt;
  logic [SW-1:0] ws_r, ws_nxt, wk_r, wk_nxt;
  logic [CW-1:0] count_r, count_nxt, fresh_r, fresh_nxt;
  req_t          op_r, op_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt, vout_r, vout_nxt;

  logic                    out_v_r, out_ok_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic [CW-1:0]           out_cnt_r;

  logic          fin, fin_ok;
  logic [SW-1:0] e_addr, l_addr, l_wdata, l_rdata;
  logic          e_we, l_we;
  logic [VAL_W-1:0] e_rdata;

  logic accept, empty, full, at_last, use_chain;
  req_t req;

  assign req       = req_t'(in_req.req_type);
  assign accept    = in_req.valid && in_req.ready;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(CAPACITY));
  assign at_last   = (CW'(pos_r) + CW'(1) >= count_r);
  assign use_chain = (fresh_r > count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req)
            REQ_INS_AFTER, REQ_INS_BEFORE: begin
              if (!full) state_nxt = use_chain ? ST_ALLOC_W : ST_INS;
            end
            REQ_GET:    if (!empty) state_nxt = ST_GET_W;
            REQ_REMOVE: if (!empty) state_nxt = ST_REM_W;
            REQ_END:    if (!empty) state_nxt = ST_WALK;
            REQ_NEXT:   if (!empty && !at_last) state_nxt = ST_NEXT_W;
            REQ_PRIOR:  if (!empty && pos_r != '0) state_nxt = ST_WALK;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_GET_W, ST_NEXT_W, ST_AFT_LINK: state_nxt = ST_IDLE;
      ST_ALLOC_W: state_nxt = ST_INS;
      ST_INS: begin
        if (empty) state_nxt = ST_IDLE;
        else if (op_r == REQ_INS_AFTER) state_nxt = ST_AFT_W;
        else state_nxt = (pos_r == '0) ? ST_IDLE : ST_WALK;
      end
      ST_AFT_W:  state_nxt = ST_AFT_LINK;
      ST_REM_W:  state_nxt = (pos_r == '0) ? ST_IDLE : ST_WALK;
      ST_WALK:   state_nxt = (wk_r == '0) ? ST_IDLE : ST_WALK_W;
      ST_WALK_W: state_nxt = ST_WALK;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory controls and results
  always_comb begin
    head_nxt = head_r; cur_nxt = cur_r; pos_nxt = pos_r; fhead_nxt = fhead_r;
    new_nxt = new_r; nx_nxt = nx_r; ws_nxt = ws_r; wk_nxt = wk_r;
    count_nxt = count_r; fresh_nxt = fresh_r; op_nxt = op_r;
    val_nxt = val_r; vout_nxt = vout_r;
    fin = 1'b0; fin_ok = 1'b0;
    e_addr = cur_r; e_we = 1'b0;
    l_addr = cur_r; l_we = 1'b0; l_wdata = fhead_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt = req; val_nxt = in_req.value_in; vout_nxt = '0;
          case (req)
            REQ_INS_AFTER, REQ_INS_BEFORE: begin
              if (full) begin
                fin = 1'b1;
              end else if (use_chain) begin
                l_addr = fhead_r;
              end else begin
                new_nxt = SW'(fresh_r); fresh_nxt = fresh_r + CW'(1);
              end
            end
            REQ_GET:    fin = empty;
            REQ_REMOVE: fin = empty;
            REQ_BEGIN: begin
              fin = 1'b1; fin_ok = !empty;
              if (!empty) begin cur_nxt = head_r; pos_nxt = '0; end
            end
            REQ_END: begin
              fin = empty; ws_nxt = head_r; wk_nxt = SW'(count_r - CW'(1));
            end
            REQ_NEXT:  fin = empty || at_last;
            REQ_PRIOR: begin
              fin = empty || (pos_r == '0); ws_nxt = head_r; wk_nxt = pos_r - SW'(1);
            end
            REQ_CLEAR: begin
              fin = 1'b1; fin_ok = 1'b1; count_nxt = '0; fresh_nxt = '0;
              head_nxt = '0; cur_nxt = '0; pos_nxt = '0;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_GET_W: begin
        vout_nxt = e_rdata; fin = 1'b1; fin_ok = 1'b1;
      end
      ST_NEXT_W: begin
        cur_nxt = l_rdata; pos_nxt = pos_r + SW'(1); fin = 1'b1; fin_ok = 1'b1;
      end
      ST_ALLOC_W: begin
        new_nxt = fhead_r; fhead_nxt = l_rdata;
      end
      ST_INS: begin
        e_addr = new_r; e_we = 1'b1;
        if (empty) begin
          head_nxt = new_r; cur_nxt = new_r; pos_nxt = '0;
          count_nxt = count_r + CW'(1); fin = 1'b1; fin_ok = 1'b1;
        end else if (op_r == REQ_INS_AFTER) begin
          l_addr = cur_r;
        end else begin
          l_addr = new_r; l_we = 1'b1; l_wdata = cur_r;
          ws_nxt = head_r; wk_nxt = pos_r - SW'(1);
          if (pos_r == '0) begin
            head_nxt = new_r; cur_nxt = new_r;
            count_nxt = count_r + CW'(1); fin = 1'b1; fin_ok = 1'b1;
          end
        end
      end
      ST_AFT_W: begin
        l_addr = new_r; l_we = 1'b1; l_wdata = l_rdata;
      end
      ST_AFT_LINK: begin
        l_addr = cur_r; l_we = 1'b1; l_wdata = new_r;
        cur_nxt = new_r; pos_nxt = pos_r + SW'(1);
        count_nxt = count_r + CW'(1); fin = 1'b1; fin_ok = 1'b1;
      end
      ST_REM_W: begin
        // push the removed slot onto the free chain
        vout_nxt = e_rdata; nx_nxt = l_rdata;
        l_addr = cur_r; l_we = 1'b1; l_wdata = fhead_r; fhead_nxt = cur_r;
        ws_nxt = head_r; wk_nxt = pos_r - SW'(1);
        if (pos_r == '0) begin
          head_nxt = (count_r == CW'(1)) ? '0 : l_rdata;
          cur_nxt  = (count_r == CW'(1)) ? '0 : l_rdata;
          count_nxt = count_r - CW'(1); fin = 1'b1; fin_ok = 1'b1;
        end
      end
      ST_WALK: begin
        l_addr = ws_r;
        if (wk_r == '0) begin
          fin = 1'b1; fin_ok = 1'b1;
          case (op_r)
            REQ_END: begin
              cur_nxt = ws_r; pos_nxt = SW'(count_r - CW'(1));
            end
            REQ_PRIOR: begin
              cur_nxt = ws_r; pos_nxt = pos_r - SW'(1);
            end
            REQ_INS_BEFORE: begin
              l_we = 1'b1; l_wdata = new_r; cur_nxt = new_r;
              count_nxt = count_r + CW'(1);
            end
            REQ_REMOVE: begin
              l_we = 1'b1; l_wdata = nx_r; count_nxt = count_r - CW'(1);
              cur_nxt = at_last ? ws_r : nx_r;
              pos_nxt = at_last ? pos_r - SW'(1) : pos_r;
            end
            default: fin_ok = 1'b0;
          endcase
        end
      end
      ST_WALK_W: begin
        ws_nxt = l_rdata; wk_nxt = wk_r - SW'(1);
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; count_r <= '0; fresh_r <= '0; head_r <= '0;
      cur_r <= '0; pos_r <= '0; out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; fresh_r <= fresh_nxt;
      head_r <= head_nxt; cur_r <= cur_nxt; pos_r <= pos_nxt;
      if (fin) out_v_r <= 1'b1;
      else if (out_rsp.ready) out_v_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fhead_r <= fhead_nxt; new_r <= new_nxt; nx_r <= nx_nxt; ws_r <= ws_nxt;
    wk_r <= wk_nxt; op_r <= op_nxt; val_r <= val_nxt; vout_r <= vout_nxt;
    if (fin) begin
      out_ok_r  <= fin_ok;
      out_val_r <= fin_ok ? vout_nxt : '0;
      out_cnt_r <= count_nxt;
    end
  end

  cle_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_elem (
    .clk(clk), .addr(e_addr), .we(e_we), .wdata(val_r), .rdata(e_rdata)
  );

  cle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .addr(l_addr), .we(l_we), .wdata(l_wdata), .rdata(l_rdata)
  );

  assign in_req.ready      = (state_r == ST_IDLE) && !out_v_r;
  assign out_rsp.valid     = out_v_r;
  assign out_rsp.ok        = out_ok_r;
  assign out_rsp.value_out = out_val_r;
  assign out_rsp.is_empty  = (out_cnt_r == '0);
  assign out_rsp.is_full   = (out_cnt_r == CW'(CAPACITY));
  assign out_rsp.count     = COUNT_W'(out_cnt_r);

  // never exceed capacity
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(CAPACITY))
    else $error("element count beyond capacity");
  // free chain length is never negative
  assert property (@(posedge clk) disable iff (!rst_n) fresh_r >= count_r)
    else $error("fill mark below element count");
  // a finished request always leaves the engine idle
  assert property (@(posedge clk) disable iff (!rst_n) fin |=> state_r == ST_IDLE)
    else $error("result raised outside idle return");
  // cursor position stays inside the list
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !empty) |-> CW'(pos_r) < count_r)
    else $error("cursor position past list end");

endmodule

// ----- verif/tb_cursor_list_engine.sv -----
`timescale 1ns / 100ps
module tb_cursor_list_engine;
  import cle_pkg::*;

  localparam int CAP      = 16;
  localparam int N_RANDOM = 1530;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic              ok;
    logic signed [31:0] value_out;
    logic              is_empty;
    logic              is_full;
    logic [4:0]        count;
  } rsp_t;

  typedef struct {
    logic [3:0]         code;
    logic signed [31:0] value;
    bit                 typed;
    rsp_t               rsp;
  } row_t;

  logic clk;
  logic rst_n;

  cle_req_if in_req ();
  cle_rsp_if out_rsp ();

  cursor_list_engine #(.CAPACITY(CAP)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req.sink),
    .out_rsp(out_rsp.source)
  );

  // list contents in order, and the cursor's position within it
  logic signed [31:0] list_vals[$];
  int                 cur_pos;

  rsp_t  pending_rsps[$];
  int    fail_cnt;
  int    idle_cycles;
  bit    stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // compute the result of one request and update the shadow list
  function automatic rsp_t list_apply(logic [3:0] code, logic signed [31:0] v);
    rsp_t r;
    r = '0;
    case (code)
      REQ_INS_AFTER: begin
        if (list_vals.size() < CAP) begin
          if (list_vals.size() == 0) begin
            list_vals.push_back(v);
            cur_pos = 0;
          end else begin
            list_vals.insert(cur_pos + 1, v);
            cur_pos++;
          end
          r.ok = 1'b1;
        end
      end
      REQ_INS_BEFORE: begin
        if (list_vals.size() < CAP) begin
          if (list_vals.size() == 0) cur_pos = 0;
          list_vals.insert(cur_pos, v);
          r.ok = 1'b1;
        end
      end
      REQ_GET: begin
        if (list_vals.size() > 0) begin
          r.value_out = list_vals[cur_pos];
          r.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (list_vals.size() > 0) begin
          r.value_out = list_vals[cur_pos];
          list_vals.delete(cur_pos);
          if (cur_pos >= list_vals.size()) cur_pos = (list_vals.size() > 0) ?
                                                     list_vals.size() - 1 : 0;
          r.ok = 1'b1;
        end
      end
      REQ_BEGIN: if (list_vals.size() > 0) begin
        cur_pos = 0;
        r.ok = 1'b1;
      end
      REQ_END: if (list_vals.size() > 0) begin
        cur_pos = list_vals.size() - 1;
        r.ok = 1'b1;
      end
      REQ_NEXT: if (cur_pos + 1 < list_vals.size()) begin
        cur_pos++;
        r.ok = 1'b1;
      end
      REQ_PRIOR: if (list_vals.size() > 0 && cur_pos > 0) begin
        cur_pos--;
        r.ok = 1'b1;
      end
      REQ_CLEAR: begin
        list_vals.delete();
        cur_pos = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.is_empty = (list_vals.size() == 0);
    r.is_full  = (list_vals.size() >= CAP);
    r.count    = 5'(list_vals.size());
    return r;
  endfunction

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one beat, hold until accepted
  task automatic send_beat(logic [3:0] code, logic signed [31:0] v);
    in_req.valid    <= 1'b1;
    in_req.req_type <= code;
    in_req.value_in <= v;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // weighted random request: inserts favoured so the list fills and drains
  function automatic logic [3:0] pick_code(int phase);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 2)  return 4'($urandom_range(9, 15));
    if (sel < 3)  return REQ_CLEAR;
    if (phase == 0 && sel < 45) return ($urandom_range(0, 1)) ? REQ_INS_AFTER : REQ_INS_BEFORE;
    if (phase == 1 && sel < 20) return ($urandom_range(0, 1)) ? REQ_INS_AFTER : REQ_INS_BEFORE;
    if (phase == 1 && sel < 40) return REQ_REMOVE;
    return 4'($urandom_range(0, 7));
  endfunction

  // directed table and random stimulus
  initial begin
    row_t rows[$];
    row_t rw;
    rsp_t exp_rsp;
    int   phase;
    in_req.valid    <= 1'b0;
    in_req.req_type <= REQ_GET;
    in_req.value_in <= '0;
    rst_n           <= 1'b0;
    stim_done       = 1'b0;
    cur_pos         = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // refusals on an empty list, then extremes and edges
    rows = '{
      '{REQ_GET,        32'sd0,          1, '{1'b0, 32'sd0, 1'b1, 1'b0, 5'd0}},
      '{REQ_REMOVE,     32'sd0,          1, '{1'b0, 32'sd0, 1'b1, 1'b0, 5'd0}},
      '{REQ_BEGIN,      32'sd0,          1, '{1'b0, 32'sd0, 1'b1, 1'b0, 5'd0}},
      '{REQ_END,        32'sd0,          1, '{1'b0, 32'sd0, 1'b1, 1'b0, 5'd0}},
      '{REQ_NEXT,       32'sd0,          1, '{1'b0, 32'sd0, 1'b1, 1'b0, 5'd0}},
      '{REQ_PRIOR,      32'sd0,          1, '{1'b0, 32'sd0, 1'b1, 1'b0, 5'd0}},
      '{4'd15,          32'sd0,          1, '{1'b0, 32'sd0, 1'b1, 1'b0, 5'd0}},
      '{REQ_INS_AFTER,  32'h7fffffff,    1, '{1'b1, 32'sd0, 1'b0, 1'b0, 5'd1}},
      '{REQ_GET,        32'sd0,          1, '{1'b1, 32'h7fffffff, 1'b0, 1'b0, 5'd1}},
      '{REQ_INS_BEFORE, 32'h80000000,    0, '{default: '0}},
      '{REQ_GET,        32'sd0,          0, '{default: '0}},
      '{REQ_PRIOR,      32'sd0,          0, '{default: '0}},
      '{REQ_NEXT,       32'sd0,          0, '{default: '0}},
      '{REQ_NEXT,       32'sd0,          0, '{default: '0}},
      '{REQ_INS_AFTER,  32'hffffffff,    0, '{default: '0}},
      '{REQ_BEGIN,      32'sd0,          0, '{default: '0}},
      '{REQ_INS_BEFORE, 32'h5a5a5a5a,    0, '{default: '0}},
      '{REQ_END,        32'sd0,          0, '{default: '0}},
      '{REQ_REMOVE,     32'sd0,          0, '{default: '0}},
      '{REQ_BEGIN,      32'sd0,          0, '{default: '0}},
      '{REQ_REMOVE,     32'sd0,          0, '{default: '0}},
      '{4'd9,           32'h12345678,    0, '{default: '0}},
      '{REQ_CLEAR,      32'sd0,          1, '{1'b1, 32'sd0, 1'b1, 1'b0, 5'd0}},
      '{REQ_REMOVE,     32'sd0,          1, '{1'b0, 32'sd0, 1'b1, 1'b0, 5'd0}}
    };
    foreach (rows[i]) begin
      rw = rows[i];
      exp_rsp = list_apply(rw.code, rw.value);
      if (rw.typed) exp_rsp = rw.rsp;
      pending_rsps.push_back(exp_rsp);
      send_beat(rw.code, rw.value);
      idle_gap(gap_len());
    end

    // fill to capacity, refuse one more, then partly drain by removes mixed with END requests
    for (int k = 0; k < CAP + 1; k++) begin
      rw.code  = (k % 2) ? REQ_INS_BEFORE : REQ_INS_AFTER;
      rw.value = $urandom;
      pending_rsps.push_back(list_apply(rw.code, rw.value));
      send_beat(rw.code, rw.value);
      idle_gap(gap_len());
    end
    for (int k = 0; k < CAP + 1; k++) begin
      rw.code = (k % 3 == 0) ? REQ_END : REQ_REMOVE;
      pending_rsps.push_back(list_apply(rw.code, '0));
      send_beat(rw.code, '0);
      idle_gap(gap_len());
    end

    // random: alternate filling and churning phases
    phase = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (list_vals.size() >= CAP - 1) phase = 1;
      else if (list_vals.size() <= 1) phase = 0;
      rw.code  = pick_code(phase);
      case ($urandom_range(0, 3))
        0:       rw.value = 32'h80000000 ^ $urandom_range(0, 3);
        1:       rw.value = 32'h7fffffff ^ $urandom_range(0, 3);
        default: rw.value = $urandom;
      endcase
      pending_rsps.push_back(list_apply(rw.code, rw.value));
      send_beat(rw.code, rw.value);
      // back to back in every third block of beats
      if ((n / 200) % 3 != 2) idle_gap(gap_len());
    end
    in_req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side: random stalls, compare with the oldest expectation
  initial begin
    rsp_t exp_rsp;
    int   stall;
    out_rsp.ready <= 1'b0;
    fail_cnt = 0;
    @(posedge rst_n);
    forever begin
      stall = (($time / 20000) % 4 == 3) ? 0 : gap_len();
      if (stall > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      @(posedge clk);
      while (!out_rsp.valid) @(posedge clk);
      if (pending_rsps.size() == 0) begin
        $error("unexpected result beat");
        fail_cnt++;
      end else begin
        exp_rsp = pending_rsps.pop_front();
        if (out_rsp.ok !== exp_rsp.ok) begin
          $error("ok: expected %0d, got %0d", exp_rsp.ok, out_rsp.ok);
          fail_cnt++;
        end
        if (out_rsp.value_out !== exp_rsp.value_out) begin
          $error("value_out: expected %0d, got %0d", exp_rsp.value_out, out_rsp.value_out);
          fail_cnt++;
        end
        if (out_rsp.is_empty !== exp_rsp.is_empty) begin
          $error("is_empty: expected %0d, got %0d", exp_rsp.is_empty, out_rsp.is_empty);
          fail_cnt++;
        end
        if (out_rsp.is_full !== exp_rsp.is_full) begin
          $error("is_full: expected %0d, got %0d", exp_rsp.is_full, out_rsp.is_full);
          fail_cnt++;
        end
        if (out_rsp.count !== exp_rsp.count) begin
          $error("count: expected %0d, got %0d", exp_rsp.count, out_rsp.count);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n) idle_cycles <= 0;
    else if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // finish once everything has drained, or when the watchdog limit is reached
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= WD_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else if (stim_done && pending_rsps.size() == 0) begin
        repeat (2 * CAP + 20) @(posedge clk);
        if (fail_cnt == 0 && pending_rsps.size() == 0) begin
          $display("RESULT: OK");
        end else begin
          $display("RESULT: ERROR");
        end
        $finish;
      end
    end
  end

endmodule
